// ===== rtl/flow_window_swipe_decider_assert.svh =====
// ----------------------------------------------------------------------------
// swipe decider assertion macros
// shared property forms, clocked on clk_i and disabled during reset
// ----------------------------------------------------------------------------
`ifndef FLOW_WINDOW_SWIPE_DECIDER_ASSERT_SVH
`define FLOW_WINDOW_SWIPE_DECIDER_ASSERT_SVH

// same-cycle implication
`define FWSD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FWSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles
`define FWSD_ASSERT_DELAY(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// ===== rtl/fwsd_pkg.sv =====
// ----------------------------------------------------------------------------
// fwsd_pkg
// sizes, payload types, codes and the cell weight table of the swipe decider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fwsd_pkg;

  // grid and window geometry
  localparam int CELL_ROWS     = 6;
  localparam int CELL_COLS     = 8;
  localparam int WINDOW_FRAMES = 8;
  localparam int NUM_CELLS     = CELL_ROWS * CELL_COLS;
  localparam int HIST_DEPTH    = WINDOW_FRAMES * NUM_CELLS;

  // field widths
  localparam int FLOW_W    = 16;
  localparam int DZ_W      = 15;
  localparam int LIM_W     = 25;
  localparam int WS_W      = 26;
  localparam int SWIPE_W   = 2;
  localparam int CFG_W     = 25;
  localparam int CFG_IDX_W = 1;

  // internal widths
  localparam int SUM_W  = FLOW_W + $clog2(WINDOW_FRAMES) + 1;
  localparam int PROD_W = SUM_W + 2;
  localparam int ACC_W  = PROD_W + $clog2(NUM_CELLS);
  localparam int CELL_AW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int HIST_AW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int ROW_W   = (CELL_ROWS > 1) ? $clog2(CELL_ROWS) : 1;
  localparam int COL_W   = (CELL_COLS > 1) ? $clog2(CELL_COLS) : 1;
  localparam int FH_W    = $clog2(WINDOW_FRAMES + 1);

  // result queue
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  // config reset values
  localparam logic [DZ_W-1:0]  DEAD_ZONE_RST = DZ_W'(512);
  localparam logic [LIM_W-1:0] LIMIT_RST     = LIM_W'(12800);

  typedef logic signed [FLOW_W-1:0] flow_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [WS_W-1:0]   ws_t;
  typedef logic signed [2:0]        weight_t;

  // saturation bounds of the reported sum
  localparam acc_t WS_MAX = ACC_W'((64'sd1 <<< (WS_W - 1)) - 64'sd1);
  localparam acc_t WS_MIN = ACC_W'(-(64'sd1 <<< (WS_W - 1)));

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEAD_ZONE      = 1'b0,
    REG_DECISION_LIMIT = 1'b1
  } cfg_reg_e;

  typedef enum logic [SWIPE_W-1:0] {
    SWIPE_NONE = 2'd0,
    SWIPE_PREV = 2'd1,
    SWIPE_NEXT = 2'd2
  } swipe_e;

  // weight codes
  localparam weight_t WT_N2 = -3'sd2;
  localparam weight_t WT_N1 = -3'sd1;
  localparam weight_t WT_Z  = 3'sd0;
  localparam weight_t WT_P1 = 3'sd1;
  localparam weight_t WT_P2 = 3'sd2;

  // fixed weight table, rows top to bottom
  localparam int WTAB_ROWS = 6;
  localparam int WTAB_COLS = 8;
  localparam int WT_RW     = 3;
  localparam int WT_CW     = 3;
  localparam weight_t WTAB [WTAB_ROWS][WTAB_COLS] = '{
    '{WT_N2, WT_N1, WT_Z,  WT_P2, WT_P2, WT_Z,  WT_N2, WT_N2},
    '{WT_N2, WT_Z,  WT_P2, WT_P2, WT_P2, WT_P2, WT_Z,  WT_N2},
    '{WT_P2, WT_P2, WT_P2, WT_P2, WT_P2, WT_P2, WT_P2, WT_P2},
    '{WT_P2, WT_P2, WT_P2, WT_P2, WT_P2, WT_P2, WT_P2, WT_P2},
    '{WT_N2, WT_Z,  WT_P2, WT_P2, WT_P2, WT_P2, WT_Z,  WT_N2},
    '{WT_N2, WT_N2, WT_Z,  WT_P2, WT_P2, WT_Z,  WT_N2, WT_N2}
  };

  // weight of a grid cell, zero outside the table
  function automatic weight_t weight_of(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    weight_t w;
    w = WT_Z;
    if (int'(row) < WTAB_ROWS && int'(col) < WTAB_COLS) begin
      w = WTAB[WT_RW'(row)][WT_CW'(col)];
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fwsd_if.sv =====
// ----------------------------------------------------------------------------
// fwsd stream interfaces
// valid/ready channels for flow samples in and swipe decisions out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// one flow sample per beat
interface fwsd_in_if;
  import fwsd_pkg::*;
  logic  valid;
  logic  ready;
  flow_t flow_x;
  modport source (output valid, output flow_x, input ready);
  modport sink   (input valid, input flow_x, output ready);
endinterface

// one frame decision per beat
interface fwsd_out_if;
  import fwsd_pkg::*;
  logic               valid;
  logic               ready;
  logic [SWIPE_W-1:0] swipe;
  ws_t                weighted_sum;
  modport source (output valid, output swipe, output weighted_sum, input ready);
  modport sink   (input valid, input swipe, input weighted_sum, output ready);
endinterface

`default_nettype wire

// ===== rtl/flow_window_swipe_decider.sv =====
// ----------------------------------------------------------------------------
// flow_window_swipe_decider
// Horizontal swipe detector. Flow samples arrive one grid cell per beat in
// raster order (6 rows of 8 cells per frame). Each beat updates its cell's
// window sum over the last 8 frames; at the frame's last cell one decision
// beat carries the weighted sum and previous/next/none.
//
// in_ch : flow_x, signed Q8.8, one cell per beat.
// out_ch: swipe and weighted_sum, one beat per frame.
// cfg   : cfg_we_i writes cfg_data_i into register cfg_idx_i (0 dead zone,
//         1 decision limit); write only while no frame is in flight.
// Path: the frame's decision is saturated, queued and then offered on out_ch.
// Throughput: one cell per cycle unless in_ch holds off, set by the one read
// and one write port of the window-sum and history memories; each cell is read
// on accept, then modified and written in stage 1, forwarded when back-to-back beats hit one entry.
// Stall: decisions collect in a 4-entry queue; with the receiver stalled,
// in_ch only holds off at a frame's last cell when queued plus in-flight
// decisions already reach 4. Other cells keep flowing.
// Reset: counters, running sum and queue clear, registers take defaults;
// window sums read as zero during the first frame, no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module flow_window_swipe_decider (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  fwsd_in_if.sink                          in_ch,
  fwsd_out_if.source                       out_ch,
  input  wire                              cfg_we_i,
  input  fwsd_pkg::cfg_reg_e               cfg_idx_i,
  input  wire [fwsd_pkg::CFG_W-1:0]        cfg_data_i
);
  import fwsd_pkg::*;

  `include "flow_window_swipe_decider_assert.svh"

  // config registers
  logic [DZ_W-1:0]  dead_zone_q;
  logic [LIM_W-1:0] limit_q;

  // frame position
  logic [CELL_AW-1:0] idx_q;
  logic [ROW_W-1:0]   row_q;
  logic [COL_W-1:0]   col_q;
  logic [HIST_AW-1:0] hist_addr_q;
  logic [FH_W-1:0]    frames_held_q;

  // memories
  sum_t  cell_mem [NUM_CELLS];
  flow_t hist_mem [HIST_DEPTH];
  sum_t  sum_rd_q;
  flow_t hist_rd_q;

  // stage 1: read data back, modify, write
  logic               s1_valid_q;
  logic               s1_last_q;
  flow_t              s1_flow_q;
  logic [CELL_AW-1:0] s1_idx_q;
  logic [HIST_AW-1:0] s1_haddr_q;
  weight_t            s1_wt_q;
  logic               s1_first_q;
  logic               s1_sub_q;
  logic               s1_sfwd_q;
  logic               s1_hfwd_q;
  sum_t               sfwd_val_q;
  flow_t              hfwd_val_q;

  // stage 2: weight and accumulate
  logic    s2_valid_q;
  logic    s2_last_q;
  sum_t    s2_sum_q;
  weight_t s2_wt_q;
  acc_t    running_q;

  // stage 3: saturate and decide
  logic s3_valid_q;
  acc_t s3_total_q;

  // result queue
  logic [SWIPE_W-1:0] fifo_swipe_q [OUT_DEPTH];
  ws_t                fifo_ws_q    [OUT_DEPTH];
  logic [OUT_AW-1:0]  wr_q;
  logic [OUT_AW-1:0]  rd_q;
  logic [OUT_CW-1:0]  cnt_q;

  logic              last_now;
  logic [OUT_CW:0]   occ;
  logic              in_fire;
  logic              out_fire;
  logic [FLOW_W:0]   flow_ext;
  logic [FLOW_W:0]   mag;
  flow_t             dz_flow;
  weight_t           wt_now;
  sum_t              old_sum;
  flow_t             old_hist;
  sum_t              new_sum;
  prod_t             prod_ext;
  prod_t             prod;
  acc_t              acc_next;
  ws_t               ws_sat;
  logic signed [WS_W:0] ws_ext;
  logic signed [WS_W:0] lim_ext;
  logic [SWIPE_W-1:0]   swipe_d;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_zone_q <= DEAD_ZONE_RST;
      limit_q     <= LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEAD_ZONE:      dead_zone_q <= cfg_data_i[DZ_W-1:0];
        REG_DECISION_LIMIT: limit_q     <= cfg_data_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // input handshake, held off only when a decision could overflow the queue
  assign last_now = (idx_q == CELL_AW'(NUM_CELLS - 1));
  assign occ = (OUT_CW + 1)'(cnt_q) + (OUT_CW + 1)'(s1_last_q) + (OUT_CW + 1)'(s2_last_q)
             + (OUT_CW + 1)'(s3_valid_q);
  assign in_ch.ready = !last_now || (occ < (OUT_CW + 1)'(OUT_DEPTH));
  assign in_fire  = in_ch.valid && in_ch.ready;

  // dead zone on the incoming beat
  assign flow_ext = {in_ch.flow_x[FLOW_W-1], in_ch.flow_x};
  assign mag      = flow_ext[FLOW_W] ? (-flow_ext) : flow_ext;
  assign dz_flow  = (mag < (FLOW_W + 1)'(dead_zone_q)) ? flow_t'(0) : in_ch.flow_x;
  assign wt_now   = weight_of(row_q, col_q);

  // frame position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q         <= '0;
      row_q         <= '0;
      col_q         <= '0;
      hist_addr_q   <= '0;
      frames_held_q <= '0;
    end else if (in_fire) begin
      hist_addr_q <= (hist_addr_q == HIST_AW'(HIST_DEPTH - 1)) ? '0
                   : hist_addr_q + HIST_AW'(1);
      if (last_now) begin
        idx_q <= '0;
        row_q <= '0;
        col_q <= '0;
        if (frames_held_q < FH_W'(WINDOW_FRAMES)) begin
          frames_held_q <= frames_held_q + FH_W'(1);
        end
      end else begin
        idx_q <= idx_q + CELL_AW'(1);
        if (col_q == COL_W'(CELL_COLS - 1)) begin
          col_q <= '0;
          row_q <= row_q + ROW_W'(1);
        end else begin
          col_q <= col_q + COL_W'(1);
        end
      end
    end
  end

  // stage 1 modify: new window sum of the cell
  assign old_sum  = s1_first_q ? sum_t'(0) : (s1_sfwd_q ? sfwd_val_q : sum_rd_q);
  assign old_hist = s1_hfwd_q ? hfwd_val_q : hist_rd_q;
  assign new_sum  = old_sum + SUM_W'(s1_flow_q) - (s1_sub_q ? SUM_W'(old_hist) : sum_t'(0));

  // memory ports: read on accept, write back from stage 1
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sum_rd_q  <= cell_mem[idx_q];
      hist_rd_q <= hist_mem[hist_addr_q];
    end
    if (s1_valid_q) begin
      cell_mem[s1_idx_q]   <= new_sum;
      hist_mem[s1_haddr_q] <= s1_flow_q;
    end
  end

  // stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
      s1_last_q  <= in_fire && last_now;
    end
  end

  // stage 1 payload and forwarding from the write in flight
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_flow_q  <= dz_flow;
      s1_idx_q   <= idx_q;
      s1_haddr_q <= hist_addr_q;
      s1_wt_q    <= wt_now;
      s1_first_q <= (frames_held_q == '0);
      s1_sub_q   <= (frames_held_q >= FH_W'(WINDOW_FRAMES));
      s1_sfwd_q  <= s1_valid_q && (s1_idx_q == idx_q);
      s1_hfwd_q  <= s1_valid_q && (s1_haddr_q == hist_addr_q);
      sfwd_val_q <= new_sum;
      hfwd_val_q <= s1_flow_q;
    end
  end

  // stage 2 weighting
  assign prod_ext = PROD_W'(s2_sum_q);
  always_comb begin
    case (s2_wt_q)
      WT_P2:   prod = prod_ext <<< 1;
      WT_P1:   prod = prod_ext;
      WT_N1:   prod = -prod_ext;
      WT_N2:   prod = -(prod_ext <<< 1);
      default: prod = prod_t'(0);
    endcase
  end
  assign acc_next = running_q + ACC_W'(prod);

  // stage 2 and stage 3 control with running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s2_last_q  <= 1'b0;
      s3_valid_q <= 1'b0;
      running_q  <= '0;
    end else begin
      s2_valid_q <= s1_valid_q;
      s2_last_q  <= s1_last_q;
      s3_valid_q <= s2_valid_q && s2_last_q;
      if (s2_valid_q) begin
        running_q <= s2_last_q ? acc_t'(0) : acc_next;
      end
    end
  end

  // stage 2 and stage 3 payload
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_sum_q <= new_sum;
      s2_wt_q  <= s1_wt_q;
    end
    if (s2_valid_q && s2_last_q) begin
      s3_total_q <= acc_next;
    end
  end

  // stage 3 saturate and compare against the limit
  always_comb begin
    if (s3_total_q > WS_MAX) begin
      ws_sat = WS_W'(WS_MAX);
    end else if (s3_total_q < WS_MIN) begin
      ws_sat = WS_W'(WS_MIN);
    end else begin
      ws_sat = WS_W'(s3_total_q);
    end
    ws_ext  = (WS_W + 1)'(ws_sat);
    lim_ext = signed'({2'b00, limit_q});
    if (ws_ext < -lim_ext) begin
      swipe_d = SWIPE_PREV;
    end else if (ws_ext > lim_ext) begin
      swipe_d = SWIPE_NEXT;
    end else begin
      swipe_d = SWIPE_NONE;
    end
  end

  // result queue
  assign out_fire = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (s3_valid_q) begin
        wr_q <= wr_q + OUT_AW'(1);
      end
      if (out_fire) begin
        rd_q <= rd_q + OUT_AW'(1);
      end
      cnt_q <= cnt_q + OUT_CW'(s3_valid_q) - OUT_CW'(out_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_valid_q) begin
      fifo_swipe_q[wr_q] <= swipe_d;
      fifo_ws_q[wr_q]    <= ws_sat;
    end
  end

  assign out_ch.valid        = (cnt_q != '0);
  assign out_ch.swipe        = fifo_swipe_q[rd_q];
  assign out_ch.weighted_sum = fifo_ws_q[rd_q];

  // checks
  `FWSD_ASSERT_IMPLIES(a_queue_room, s3_valid_q, cnt_q != OUT_CW'(OUT_DEPTH),
                       "decision queue overflow")
  `FWSD_ASSERT_DELAY(a_frame_decision, in_fire && last_now, 3, s3_valid_q,
                     "no decision for frame end")
  `FWSD_ASSERT_NEXT(a_mid_frame_quiet, s2_valid_q && !s2_last_q, !s3_valid_q,
                    "decision inside frame")
  `FWSD_ASSERT_IMPLIES(a_next_positive, out_ch.valid && out_ch.swipe == SWIPE_NEXT,
                       !out_ch.weighted_sum[WS_W-1], "next with negative sum")

endmodule

`default_nettype wire
